// ----- sv/sct_pkg.sv -----
package sct_pkg;

	// Series length: one cell per term
	localparam int TERMS = 20;

	// Register stages inside one cell
	localparam int CELL_LAT = 6;

	// Field and datapath widths
	localparam int ANGLE_W = 31;
	localparam int VALUE_W = 32;
	localparam int MAG_W = 30;
	localparam int X2_W = 60;
	localparam int TERM_W = 63;
	localparam int R_W = 60;
	localparam int SUM_W = 64;
	localparam int M_W = 64;
	localparam int PROD_W = 128;

	// Divisor (2k+s-1)(2k+s) stays below 2^13 for up to 32 terms
	localparam int D_W = 13;

	// Remainder after the reciprocal estimate stays below twice the divisor
	localparam int REM_W = 14;

	// Fraction bits of the squared angle and of the step ratio
	localparam int FRAC_SHIFT = 56;

	// Pi in Q3.28
	localparam logic signed [ANGLE_W-1:0] PI_Q28 = 31'sd843314857;

	// Numerator for the divisor reciprocals, 2^64
	localparam logic [M_W:0] RECIP_ONE = {1'b1, {M_W{1'b0}}};

	// Per-item control travelling alongside the datapath
	typedef struct packed {
		logic valid;
		logic cosine;
		logic neg;
		logic clamped;
	} ctl_t;

endpackage

// ----- sv/sine_cosine_taylor_series_core.sv -----
// Sine or cosine of a Q3.28 angle by a Maclaurin series of TERMS terms, result in
// Q1.30 rounded half away from zero and saturated to plus or minus one. Angles
// beyond plus or minus pi are clamped to pi with their sign and flagged. The core
// takes one item every cycle while item_stall is low and returns each result in
// order. The datapath is a row of one cell per term, each pipelined around its
// divide of the squared angle by a constant, done as a 64-bit reciprocal multiply
// in 32-bit partial products with one correction step. An output register holds a
// stalled result while the stages behind it keep advancing until an item reaches
// the last one; from then on the whole row and the input stall until the result is
// taken.
module sine_cosine_taylor_series_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                command,
	input  logic signed [sct_pkg::ANGLE_W-1:0]  angle,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [sct_pkg::VALUE_W-1:0]  value,
	output logic                                clamped
);
	import sct_pkg::*;

	localparam int SIN_SHIFT = 32;
	localparam int ONE_SHIFT = 60;
	localparam int OUT_SHIFT = 30;
	localparam int QS_W = VALUE_W - 1;
	localparam int QF_W = SUM_W + 1 - OUT_SHIFT;
	localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << ONE_SHIFT;
	localparam logic [R_W-1:0] R_ONE = R_W'(1) << FRAC_SHIFT;
	localparam logic [SUM_W:0] ROUND_HALF = (SUM_W+1)'(1) << (OUT_SHIFT - 1);
	localparam logic [QS_W-1:0] Q_ONE = QS_W'(1) << OUT_SHIFT;
	localparam logic [SUM_W-1:0] SUM_MIN = SUM_W'(1) << (SUM_W - 1);
	localparam logic signed [VALUE_W-1:0] VMAX = VALUE_W'(Q_ONE);
	localparam logic signed [VALUE_W-1:0] VMIN = -VMAX;

	logic pipe_en, out_en;

	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [MAG_W-1:0]  mag_s1;
	logic [X2_W-1:0]   x2_s2;
	logic [TERM_W-1:0] term_s2;
	logic [SUM_W-1:0]  smag_s3;
	logic              sneg_s3, sneg_s4;
	logic [QS_W-1:0]   qs_s4;

	logic                      result_valid_q, clamped_q;
	logic signed [VALUE_W-1:0] value_q;

	logic                     over;
	logic [ANGLE_W-1:0]       ang_abs;
	logic [SUM_W:0]           rsum;
	logic [QF_W-1:0]          qfull;
	logic [VALUE_W-1:0]       qext;
	logic                     flip;

	ctl_t              ctl_c  [0:TERMS];
	logic [X2_W-1:0]   x2_c   [0:TERMS];
	logic [TERM_W-1:0] term_c [0:TERMS];
	logic [R_W-1:0]    r_c    [0:TERMS];
	logic [SUM_W-1:0]  sum_c  [0:TERMS];

	// Advance unless a result is stuck in the output register with one behind it
	assign out_en     = !result_valid_q || !result_stall;
	assign pipe_en    = out_en || !ctl_s4.valid;
	assign item_stall = !pipe_en;

	// Clamp the angle and take its magnitude
	assign over    = (angle > PI_Q28) || (angle < -PI_Q28);
	assign ang_abs = angle[ANGLE_W-1] ? -angle : angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (pipe_en) begin
			ctl_s1.valid   <= item_valid;
			ctl_s1.cosine  <= command;
			ctl_s1.neg     <= angle[ANGLE_W-1];
			ctl_s1.clamped <= over;
			ctl_s2         <= ctl_s1;
			ctl_s3         <= ctl_c[TERMS];
			ctl_s4         <= ctl_s3;
		end
	end

	// Square the magnitude and form the leading term
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mag_s1  <= over ? MAG_W'(PI_Q28) : ang_abs[MAG_W-1:0];
			x2_s2   <= X2_W'(mag_s1) * X2_W'(mag_s1);
			term_s2 <= ctl_s1.cosine ? TERM_ONE : TERM_W'(mag_s1) << SIN_SHIFT;
		end
	end

	// Feed the first cell a unit ratio so that it passes the leading term through
	assign ctl_c[0]  = ctl_s2;
	assign x2_c[0]   = x2_s2;
	assign term_c[0] = term_s2;
	assign r_c[0]    = R_ONE;
	assign sum_c[0]  = '0;

	for (genvar k = 0; k < TERMS; k++) begin : g_cell
		localparam int NS = 2 * (k + 1) + 1;
		localparam logic [D_W-1:0] DS = D_W'((NS - 1) * NS);
		localparam logic [D_W-1:0] DC = D_W'((NS - 2) * (NS - 1));
		localparam logic [M_W-1:0] MS = M_W'(RECIP_ONE / DS);
		localparam logic [M_W-1:0] MC = M_W'(RECIP_ONE / DC);
		localparam logic SUB = (k % 2) == 1;

		sct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.ctl_in   (ctl_c[k]),
			.x2_in    (x2_c[k]),
			.term_in  (term_c[k]),
			.r_in     (r_c[k]),
			.sum_in   (sum_c[k]),
			.d_sin    (DS),
			.d_cos    (DC),
			.m_sin    (MS),
			.m_cos    (MC),
			.subtract (SUB),
			.ctl_out  (ctl_c[k+1]),
			.x2_out   (x2_c[k+1]),
			.term_out (term_c[k+1]),
			.r_out    (r_c[k+1]),
			.sum_out  (sum_c[k+1])
		);
	end

	// Restore the sign of an odd function and take the magnitude of the sum
	assign flip  = !ctl_c[TERMS].cosine && ctl_c[TERMS].neg;

	// Round to Q1.30 and saturate
	assign rsum  = {1'b0, smag_s3} + ROUND_HALF;
	assign qfull = rsum[SUM_W:OUT_SHIFT];
	assign qext  = {1'b0, qs_s4};

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			smag_s3 <= sum_c[TERMS][SUM_W-1] ? -sum_c[TERMS] : sum_c[TERMS];
			sneg_s3 <= (sum_c[TERMS][SUM_W-1] ^ flip) || (sum_c[TERMS] == SUM_MIN);
			qs_s4   <= (qfull > QF_W'(Q_ONE)) ? Q_ONE : qfull[QS_W-1:0];
			sneg_s4 <= sneg_s3;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_en) begin
			result_valid_q <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			value_q   <= sneg_s4 ? -qext : qext;
			clamped_q <= ctl_s4.clamped;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign clamped      = clamped_q;

	// Input is refused only behind a stuck result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a stalled result");

	// Result stays within plus or minus one
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (value <= VMAX && value >= VMIN))
		else $error("result outside saturation range");

	// An item leaving the last stage lands in the output register
	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_en && ctl_s4.valid) |=> result_valid)
		else $error("item lost at the output register");

endmodule

// ----- sv/sct_mul.sv -----
module sct_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [sct_pkg::M_W-1:0]     a,
	input  logic [sct_pkg::M_W-1:0]     b,
	output logic [sct_pkg::PROD_W-1:0]  p
);
	import sct_pkg::*;

	localparam int H = M_W / 2;

	logic [M_W-1:0]    ll_s1, lh_s1;
	logic [H-1:0]      a_hi_s1, b_lo_s1, b_hi_s1;
	logic [M_W-1:0]    ll_s2, lh_s2, hl_s2, hh_s2;
	logic [PROD_W-1:0] p_s3;

	// Form the low half partial products, then the high half, then sum
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= M_W'(a[H-1:0]) * M_W'(b[H-1:0]);
			lh_s1   <= M_W'(a[H-1:0]) * M_W'(b[M_W-1:H]);
			a_hi_s1 <= a[M_W-1:H];
			b_lo_s1 <= b[H-1:0];
			b_hi_s1 <= b[M_W-1:H];

			ll_s2 <= ll_s1;
			lh_s2 <= lh_s1;
			hl_s2 <= M_W'(a_hi_s1) * M_W'(b_lo_s1);
			hh_s2 <= M_W'(a_hi_s1) * M_W'(b_hi_s1);

			p_s3 <= {hh_s2, ll_s2} + (PROD_W'(lh_s2) << H) + (PROD_W'(hl_s2) << H);
		end
	end

	assign p = p_s3;

endmodule

// ----- sv/sct_cdiv.sv -----
module sct_cdiv (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sct_pkg::X2_W-1:0]  x2,
	input  logic [sct_pkg::D_W-1:0]   d,
	input  logic [sct_pkg::M_W-1:0]   m,
	output logic [sct_pkg::R_W-1:0]   r
);
	import sct_pkg::*;

	localparam int N_W = X2_W + 1;

	logic [N_W-1:0]    n_s1;
	logic [M_W-1:0]    m_s1;
	logic [D_W-1:0]    d_s1, d_s2, d_s3, d_s4, d_s5;
	logic [REM_W-1:0]  nlo_s2, nlo_s3, nlo_s4, nlo_s5;
	logic [PROD_W-1:0] prod;
	logic [N_W-1:0]    q0_s5;
	logic [REM_W-1:0]  qd_s5;
	logic [REM_W-1:0]  rem;
	logic              rem_ge;
	logic [R_W-1:0]    r_s6;

	// Estimate the quotient by the reciprocal, at most one short
	sct_mul u_mul (
		.clk (clk),
		.en  (en),
		.a   (M_W'(n_s1)),
		.b   (m_s1),
		.p   (prod)
	);

	// Remainder needs only its low bits, as it stays below twice the divisor
	assign rem    = nlo_s5 - qd_s5;
	assign rem_ge = rem >= REM_W'(d_s5);

	// Add half the divisor, hold the divisor and low numerator bits, correct
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= N_W'(x2) + N_W'(d[D_W-1:1]);
			m_s1 <= m;
			d_s1 <= d;

			d_s2   <= d_s1;
			d_s3   <= d_s2;
			d_s4   <= d_s3;
			d_s5   <= d_s4;
			nlo_s2 <= n_s1[REM_W-1:0];
			nlo_s3 <= nlo_s2;
			nlo_s4 <= nlo_s3;
			nlo_s5 <= nlo_s4;

			q0_s5 <= prod[M_W +: N_W];
			qd_s5 <= REM_W'(prod[M_W +: REM_W] * REM_W'(d_s4));

			r_s6 <= R_W'(q0_s5) + R_W'(rem_ge);
		end
	end

	assign r = r_s6;

endmodule

// ----- sv/sct_cell.sv -----
module sct_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  sct_pkg::ctl_t               ctl_in,
	input  logic [sct_pkg::X2_W-1:0]    x2_in,
	input  logic [sct_pkg::TERM_W-1:0]  term_in,
	input  logic [sct_pkg::R_W-1:0]     r_in,
	input  logic [sct_pkg::SUM_W-1:0]   sum_in,
	input  logic [sct_pkg::D_W-1:0]     d_sin,
	input  logic [sct_pkg::D_W-1:0]     d_cos,
	input  logic [sct_pkg::M_W-1:0]     m_sin,
	input  logic [sct_pkg::M_W-1:0]     m_cos,
	input  logic                        subtract,
	output sct_pkg::ctl_t               ctl_out,
	output logic [sct_pkg::X2_W-1:0]    x2_out,
	output logic [sct_pkg::TERM_W-1:0]  term_out,
	output logic [sct_pkg::R_W-1:0]     r_out,
	output logic [sct_pkg::SUM_W-1:0]   sum_out
);
	import sct_pkg::*;

	ctl_t              ctl_s [1:CELL_LAT];
	logic [X2_W-1:0]   x2_s  [1:CELL_LAT];
	logic [PROD_W-1:0] term_prod;
	logic [SUM_W-1:0]  sum_s1, sum_s2, sum_s3, sum_s4, sum_s5, sum_s6;
	logic [TERM_W-1:0] term_s4, term_s5, term_s6;

	// Scale this term from the previous one by the step ratio
	sct_mul u_term (
		.clk (clk),
		.en  (en),
		.a   (M_W'(term_in)),
		.b   (M_W'(r_in)),
		.p   (term_prod)
	);

	// Work out the step ratio for the next cell meanwhile
	sct_cdiv u_div (
		.clk (clk),
		.en  (en),
		.x2  (x2_in),
		.d   (ctl_in.cosine ? d_cos : d_sin),
		.m   (ctl_in.cosine ? m_cos : m_sin),
		.r   (r_out)
	);

	// Advance the control line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= CELL_LAT; i++) ctl_s[i] <= '0;
		end else if (en) begin
			ctl_s[1] <= ctl_in;
			for (int i = 2; i <= CELL_LAT; i++) ctl_s[i] <= ctl_s[i-1];
		end
	end

	// Round the term, fold it into the partial sum, hold the square
	always_ff @(posedge clk) begin
		if (en) begin
			x2_s[1] <= x2_in;
			for (int i = 2; i <= CELL_LAT; i++) x2_s[i] <= x2_s[i-1];

			sum_s1 <= sum_in;
			sum_s2 <= sum_s1;
			sum_s3 <= sum_s2;
			sum_s4 <= sum_s3;

			term_s4 <= term_prod[FRAC_SHIFT +: TERM_W] + TERM_W'(term_prod[FRAC_SHIFT-1]);

			sum_s5  <= subtract ? sum_s4 - SUM_W'(term_s4) : sum_s4 + SUM_W'(term_s4);
			term_s5 <= term_s4;

			sum_s6  <= sum_s5;
			term_s6 <= term_s5;
		end
	end

	assign ctl_out  = ctl_s[CELL_LAT];
	assign x2_out   = x2_s[CELL_LAT];
	assign term_out = term_s6;
	assign sum_out  = sum_s6;

endmodule
